/* sv/bde_pkg.sv */
// Shared widths, defaults and reset values for the button debounce event block.
package bde_pkg;

	// Fixed field widths of the scan and result words
	localparam int NOW_W   = 32;
	localparam int FIELD_W = 7;
	localparam int DBT_W   = 16;
	localparam int FIRST_W = 3;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_BUTTONS = 7;
	localparam int DEF_TIME_BITS   = 32;

	// Debounce time after reset, in ticks
	localparam logic [DBT_W-1:0] DBT_RESET = 16'd50;

endpackage

/* sv/bde_lanes.sv */
// Per-button debounce state, lockout timers and latched press/release flags.
module bde_lanes #(
	parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS,
	parameter int TIME_BITS   = bde_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          scan_en,
	input  logic [TIME_BITS-1:0]          now_t,
	input  logic [NUM_BUTTONS-1:0]        level_pressed,
	input  logic [NUM_BUTTONS-1:0]        ack_p,
	input  logic [NUM_BUTTONS-1:0]        ack_r,
	input  logic [bde_pkg::DBT_W-1:0]     dbt,
	output logic [NUM_BUTTONS-1:0]        held_nx,
	output logic [NUM_BUTTONS-1:0]        press_nx,
	output logic [NUM_BUTTONS-1:0]        release_nx
);
	import bde_pkg::*;

	localparam int CMP_W = (TIME_BITS > DBT_W) ? TIME_BITS : DBT_W;

	logic [NUM_BUTTONS-1:0] debounced_q;
	logic [NUM_BUTTONS-1:0] press_q;
	logic [NUM_BUTTONS-1:0] release_q;
	logic [TIME_BITS-1:0]   stamp_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] change;
	logic [TIME_BITS-1:0]   elapsed [NUM_BUTTONS];

	// Clear acknowledged flags, then accept changes that are past the lockout
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			elapsed[i] = now_t - stamp_q[i];
			change[i]  = (level_pressed[i] != debounced_q[i]) &&
			             (CMP_W'(elapsed[i]) >= CMP_W'(dbt));
			held_nx[i]    = change[i] ? level_pressed[i] : debounced_q[i];
			press_nx[i]   = (press_q[i] & ~ack_p[i]) | (change[i] & level_pressed[i]);
			release_nx[i] = (release_q[i] & ~ack_r[i]) | (change[i] & ~level_pressed[i]);
		end
	end

	// Commit the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounced_q <= '0;
			press_q     <= '0;
			release_q   <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (scan_en) begin
			debounced_q <= held_nx;
			press_q     <= press_nx;
			release_q   <= release_nx;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (change[i]) begin
					stamp_q[i] <= now_t;
				end
			end
		end
	end

	// Debounced state only moves on a scan
	a_state_only_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_en |=> $stable(debounced_q))
		else $error("debounced state changed without a scan");

	// A new press flag needs a button that is now held
	a_press_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_en && ((press_nx & ~press_q) != '0)) |->
		((press_nx & ~press_q & ~held_nx) == '0))
		else $error("press flag raised on a released button");

endmodule

/* sv/bde_first.sv */
// Priority encoder for the lowest-numbered held button.
module bde_first #(
	parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS
) (
	input  logic [NUM_BUTTONS-1:0]      held_vec,
	output logic [bde_pkg::FIRST_W-1:0] first
);
	import bde_pkg::*;

	// Scan from the top down so the lowest held button wins
	always_comb begin
		first = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (held_vec[i]) begin
				first = FIRST_W'(i + 1);
			end
		end
	end

endmodule

/* sv/button_debounce_events_top.sv */
// Top level of the button debounce event block: handshakes, scan and result registers.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_stall   | now_ms, pin_levels, ack_pressed, ack_released
//   out     | output    | out_valid/out_stall | held, press_flags, release_flags, first_held
//   cfg     | input     | cfg_valid/cfg_ready | debounce_time
//
// One scan a cycle unless out_stall holds the result register; a scan's result is offered
// from the edge after it is taken, later only while the result register is stalled.
// The input register is evaluated and committed to the button state as it advances,
// the result register then holds the word until the consumer takes it.
// Reset clears every button (released, no flags, stamp zero) and sets the
// debounce time to 50. An out_stall backs up into in_stall in the same cycle.
module button_debounce_events_top #(
	parameter int NUM_BUTTONS = bde_pkg::DEF_NUM_BUTTONS,
	parameter int TIME_BITS   = bde_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bde_pkg::NOW_W-1:0]     now_ms,
	input  logic [bde_pkg::FIELD_W-1:0]   pin_levels,
	input  logic [bde_pkg::FIELD_W-1:0]   ack_pressed,
	input  logic [bde_pkg::FIELD_W-1:0]   ack_released,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bde_pkg::FIELD_W-1:0]   held,
	output logic [bde_pkg::FIELD_W-1:0]   press_flags,
	output logic [bde_pkg::FIELD_W-1:0]   release_flags,
	output logic [bde_pkg::FIRST_W-1:0]   first_held,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bde_pkg::DBT_W-1:0]     debounce_time
);
	import bde_pkg::*;

	logic                   valid_s1;
	logic [NOW_W-1:0]       now_s1;
	logic [FIELD_W-1:0]     pins_s1;
	logic [FIELD_W-1:0]     ackp_s1;
	logic [FIELD_W-1:0]     ackr_s1;
	logic                   valid_s2;
	logic [FIELD_W-1:0]     held_s2;
	logic [FIELD_W-1:0]     press_s2;
	logic [FIELD_W-1:0]     release_s2;
	logic [FIRST_W-1:0]     first_s2;
	logic [DBT_W-1:0]       dbt_q;

	logic                   s2_ready;
	logic                   s1_adv;
	logic [TIME_BITS-1:0]   now_t;
	logic [NUM_BUTTONS-1:0] level_pressed;
	logic [NUM_BUTTONS-1:0] ack_p;
	logic [NUM_BUTTONS-1:0] ack_r;
	logic [NUM_BUTTONS-1:0] held_nx;
	logic [NUM_BUTTONS-1:0] press_nx;
	logic [NUM_BUTTONS-1:0] release_nx;
	logic [FIELD_W-1:0]     held_w;
	logic [FIELD_W-1:0]     press_w;
	logic [FIELD_W-1:0]     release_w;
	logic [FIRST_W-1:0]     first_w;

	// Handshake control
	assign s2_ready  = !valid_s2 || !out_stall;
	assign s1_adv    = valid_s1 && s2_ready;
	assign in_stall  = valid_s1 && !s2_ready;
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbt_q <= DBT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dbt_q <= debounce_time;
		end
	end

	// Input register: take a word whenever not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			now_s1  <= now_ms;
			pins_s1 <= pin_levels;
			ackp_s1 <= ack_pressed;
			ackr_s1 <= ack_released;
		end
	end

	// Fit the tick to the timer width
	if (TIME_BITS <= NOW_W) begin : g_time_trunc
		assign now_t = now_s1[TIME_BITS-1:0];
	end else begin : g_time_ext
		assign now_t = {{(TIME_BITS - NOW_W){1'b0}}, now_s1};
	end

	// Map pins and acks to buttons; buttons past the field width read as pressed
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_in_map
		if (i < FIELD_W) begin : g_live
			assign level_pressed[i] = ~pins_s1[i];
			assign ack_p[i]         = ackp_s1[i];
			assign ack_r[i]         = ackr_s1[i];
		end else begin : g_extra
			assign level_pressed[i] = 1'b1;
			assign ack_p[i]         = 1'b0;
			assign ack_r[i]         = 1'b0;
		end
	end

	bde_lanes #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.TIME_BITS   (TIME_BITS)
	) u_lanes (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_en       (s1_adv),
		.now_t         (now_t),
		.level_pressed (level_pressed),
		.ack_p         (ack_p),
		.ack_r         (ack_r),
		.dbt           (dbt_q),
		.held_nx       (held_nx),
		.press_nx      (press_nx),
		.release_nx    (release_nx)
	);

	bde_first #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_first (
		.held_vec (held_nx),
		.first    (first_w)
	);

	// Fit button vectors to the result fields
	for (genvar b = 0; b < FIELD_W; b++) begin : g_out_map
		if (b < NUM_BUTTONS) begin : g_live
			assign held_w[b]    = held_nx[b];
			assign press_w[b]   = press_nx[b];
			assign release_w[b] = release_nx[b];
		end else begin : g_pad
			assign held_w[b]    = 1'b0;
			assign press_w[b]   = 1'b0;
			assign release_w[b] = 1'b0;
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			held_s2    <= held_w;
			press_s2   <= press_w;
			release_s2 <= release_w;
			first_s2   <= first_w;
		end
	end

	assign out_valid     = valid_s2;
	assign held          = held_s2;
	assign press_flags   = press_s2;
	assign release_flags = release_s2;
	assign first_held    = first_s2;

	// Stall the input only when a word is waiting behind a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	// A scan moving on fills the result register on the next edge
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> valid_s2)
		else $error("scan committed but no result presented");

	// First held button agrees with the held vector
	a_first_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (NUM_BUTTONS <= FIELD_W)) |-> ((first_held == '0) == (held == '0)))
		else $error("first held button disagrees with held vector");

endmodule
